/* rtl/svmm_pkg.sv */
// svmm_pkg: shared types and constants for the sparse vector-matrix multiply.
// No dependencies.
package svmm_pkg;

   localparam int MAX_DIM     = 64;
   localparam int MAX_NONZERO = 256;
   localparam int DATA_WIDTH  = 32;
   localparam int IDX_W       = 6;
   localparam int CFG_W       = 7;
   localparam int NZ_AW       = $clog2(MAX_NONZERO);
   localparam int CNT_W       = NZ_AW + 1;
   localparam int VEC_AW      = $clog2(MAX_DIM);

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_SETV  = 2'd1;
   localparam logic [1:0] OP_SETM  = 2'd2;
   localparam logic [1:0] OP_MUL   = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_DIM   = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   localparam logic [1:0] CSR_VLEN = 2'd0;
   localparam logic [1:0] CSR_ROWS = 2'd1;
   localparam logic [1:0] CSR_COLS = 2'd2;

   typedef struct packed {
      logic [1:0]            operation;
      logic [IDX_W-1:0]      row_index;
      logic [IDX_W-1:0]      col_index;
      logic [DATA_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]      result_col;
      logic [DATA_WIDTH-1:0] result_value;
      logic [1:0]            status;
      logic                  empty_res;
      logic                  last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch accepted item
      logic clear;     // zero vector, count
      logic write_vec;
      logic scan_start;  // k <= 0
      logic scan_step;   // k++
      logic append;      // write new entry at count
      logic overwrite;   // write value at hit index
      logic col_start;   // c <= 0, sum <= 0
      logic acc;         // accumulate registered product
      logic col_next;    // c++, sum <= 0
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] op;
      logic       range_err;
      logic       dim_err;
      logic       scan_done;   // k reached count
      logic       hit;         // entry at k matches (valid after read)
      logic       full;
      logic       cols_done;   // c reached cols
      logic       sum_nz;
   } sts_type;

endpackage

/* rtl/svmm_if.sv */
// svmm_if: valid/ready channel carrying one payload item.
// Depends on nothing; payload type is given per instance.
interface svmm_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

/* rtl/svmm_datapath.sv */
// svmm_datapath: vector store, nonzero entry memory, scan index and accumulator.
// Depends on svmm_pkg.
module svmm_datapath
   import svmm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   input  req_type              item,
   input  cmd_type              cmd,
   output sts_type              sts,
   output logic [IDX_W-1:0]     cur_col,
   output logic [DATA_WIDTH-1:0] cur_sum
);

   logic [CFG_W-1:0] vlen_ff, rows_ff, cols_ff;
   req_type          item_ff;
   logic [DATA_WIDTH-1:0] vec_mem [MAX_DIM];
   logic [MAX_DIM-1:0]    vec_vld_ff;
   logic [2*IDX_W+DATA_WIDTH-1:0] nz_mem [MAX_NONZERO];
   logic [2*IDX_W+DATA_WIDTH-1:0] nz_rd_ff;
   logic [CNT_W-1:0] cnt_ff, k_ff, krd_ff;
   logic             rd_vld_ff;
   logic [CFG_W-1:0] c_ff;
   logic [DATA_WIDTH-1:0] sum_ff, vrd_ff, prod_ff, mval_ff;
   logic             prod_vld_ff, mvld_ff, vvld_ff;
   logic [CFG_W-1:0] vl, rl, cl;
   logic [IDX_W-1:0] e_row, e_col;
   logic [DATA_WIDTH-1:0] e_val;
   logic             use_ff;

   function automatic logic [CFG_W-1:0] lim(input logic [CFG_W-1:0] r);
      return (r > CFG_W'(MAX_DIM)) ? CFG_W'(MAX_DIM) : r;
   endfunction

   assign vl = lim(vlen_ff);
   assign rl = lim(rows_ff);
   assign cl = lim(cols_ff);
   assign {e_row, e_col, e_val} = nz_rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vlen_ff <= CFG_W'(1);
         rows_ff <= CFG_W'(1);
         cols_ff <= CFG_W'(1);
      end else if (csr_write) begin
         case (csr_index)
            CSR_VLEN: vlen_ff <= csr_data;
            CSR_ROWS: rows_ff <= csr_data;
            CSR_COLS: cols_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) item_ff <= item;
   end

   // vector store: valid bits give the zero reset
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) vec_vld_ff <= '0;
      else if (cmd.write_vec) vec_vld_ff[item_ff.row_index] <= 1'b1;
   end
   always_ff @(posedge clock) begin
      if (cmd.write_vec) vec_mem[item_ff.row_index] <= item_ff.value;
   end

   // entry memory, one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.append)
         nz_mem[cnt_ff[NZ_AW-1:0]] <= {item_ff.row_index, item_ff.col_index, item_ff.value};
      else if (cmd.overwrite)
         nz_mem[krd_ff[NZ_AW-1:0]] <= {item_ff.row_index, item_ff.col_index, item_ff.value};
      nz_rd_ff <= nz_mem[k_ff[NZ_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) cnt_ff <= '0;
      else if (cmd.append) cnt_ff <= cnt_ff + CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
         rd_vld_ff <= 1'b0;
         prod_vld_ff <= 1'b0;
         mvld_ff <= 1'b0;
      end else begin
         if (cmd.scan_start) k_ff <= '0;
         else if (cmd.scan_step) k_ff <= k_ff + CNT_W'(1);
         rd_vld_ff   <= cmd.scan_step && !cmd.scan_start;
         mvld_ff     <= rd_vld_ff && use_ff;
         prod_vld_ff <= mvld_ff;
      end
   end

   always_ff @(posedge clock) begin
      krd_ff <= k_ff;
   end

   // multiply pipeline: entry read -> operand regs -> product reg
   assign use_ff = (e_col == c_ff[IDX_W-1:0]) && ({1'b0, e_row} < vl) &&
                   ({1'b0, e_row} < rl);
   always_ff @(posedge clock) begin
      vrd_ff  <= vec_mem[e_row];
      vvld_ff <= vec_vld_ff[e_row];
      mval_ff <= e_val;
      prod_ff <= (vvld_ff ? vrd_ff : '0) * mval_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.col_start) begin
         c_ff <= '0;
         sum_ff <= '0;
      end else if (cmd.col_next) begin
         c_ff <= c_ff + CFG_W'(1);
         sum_ff <= '0;
      end else if (cmd.acc && prod_vld_ff) begin
         sum_ff <= sum_ff + prod_ff;
      end
   end

   always_comb begin
      sts.op        = item_ff.operation;
      sts.range_err = (item_ff.operation == OP_SETV) ? ({1'b0, item_ff.row_index} >= vl)
                    : (({1'b0, item_ff.row_index} >= rl) || ({1'b0, item_ff.col_index} >= cl));
      sts.dim_err   = vlen_ff != rows_ff;
      sts.scan_done = k_ff >= cnt_ff;
      sts.hit       = rd_vld_ff && e_row == item_ff.row_index && e_col == item_ff.col_index;
      sts.full      = cnt_ff >= CNT_W'(MAX_NONZERO);
      sts.cols_done = c_ff >= cl;
      sts.sum_nz    = sum_ff != '0;
   end

   assign cur_col = c_ff[IDX_W-1:0];
   assign cur_sum = sum_ff;

endmodule

/* rtl/svmm_ctrl.sv */
// svmm_ctrl: sequencer for set, search and column-by-column multiply.
// Depends on svmm_pkg.
module svmm_ctrl
   import svmm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output cmd_type               cmd,
   input  sts_type               sts,
   input  logic [IDX_W-1:0]      cur_col,
   input  logic [DATA_WIDTH-1:0] cur_sum,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data
);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_DEC    = 7'b0000010,
      S_SEARCH = 7'b0000100,
      S_SCAN   = 7'b0001000,
      S_DRAIN  = 7'b0010000,
      S_EMIT   = 7'b0100000,
      S_OUT    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] drain_ff, drain_in;
   logic       any_ff, any_in;
   logic       ov_ff, ov_in;
   rsp_type    out_ff, out_in;
   logic       ovalid_ff, ovalid_in;

   function automatic rsp_type ackf(input logic [1:0] st);
      rsp_type r;
      r.result_col = '0; r.result_value = '0; r.status = st;
      r.empty_res = 1'b1; r.last = 1'b1;
      return r;
   endfunction

   assign req_ready = state_ff == S_IDLE && !ovalid_ff;
   assign rsp_valid = ovalid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      state_in = state_ff; drain_in = drain_ff; any_in = any_ff; ov_in = ov_ff;
      out_in = out_ff; ovalid_in = ovalid_ff;
      cmd = '0;
      if (ovalid_ff && rsp_ready) ovalid_in = 1'b0;
      case (state_ff)
         S_IDLE: if (req_valid && req_ready) begin
            cmd.capture = 1'b1;
            state_in = S_DEC;
         end
         S_DEC: begin
            case (sts.op)
               OP_CLEAR: begin
                  cmd.clear = 1'b1; out_in = ackf(ST_OK); ovalid_in = 1'b1; state_in = S_IDLE;
               end
               OP_SETV: begin
                  if (sts.range_err) out_in = ackf(ST_RANGE);
                  else begin cmd.write_vec = 1'b1; out_in = ackf(ST_OK); end
                  ovalid_in = 1'b1; state_in = S_IDLE;
               end
               OP_SETM: begin
                  if (sts.range_err) begin
                     out_in = ackf(ST_RANGE); ovalid_in = 1'b1; state_in = S_IDLE;
                  end else begin
                     cmd.scan_start = 1'b1; state_in = S_SEARCH;
                  end
               end
               default: begin
                  if (sts.dim_err) begin
                     out_in = ackf(ST_DIM); ovalid_in = 1'b1; state_in = S_IDLE;
                  end else begin
                     cmd.col_start = 1'b1; cmd.scan_start = 1'b1; any_in = 1'b0;
                     state_in = S_SCAN;
                  end
               end
            endcase
         end
         // read entry k each cycle; hit checked on the registered read
         S_SEARCH: begin
            if (sts.hit) begin
               cmd.overwrite = 1'b1; out_in = ackf(ST_OK); ovalid_in = 1'b1;
               state_in = S_IDLE;
            end else if (sts.scan_done) begin
               if (sts.full) out_in = ackf(ST_FULL);
               else begin cmd.append = 1'b1; out_in = ackf(ST_OK); end
               ovalid_in = 1'b1; state_in = S_IDLE;
            end else cmd.scan_step = 1'b1;
         end
         S_SCAN: begin
            cmd.acc = 1'b1;
            if (sts.cols_done) begin
               if (!any_ff) begin out_in = ackf(ST_OK); ovalid_in = 1'b1; state_in = S_IDLE; end
               else if (ovalid_in) ; // wait for slot
               else begin
                  out_in.last = 1'b1; ovalid_in = 1'b1; ov_in = 1'b0; state_in = S_IDLE;
               end
            end else if (sts.scan_done) begin
               drain_in = 2'd3; state_in = S_DRAIN;
            end else cmd.scan_step = 1'b1;
         end
         S_DRAIN: begin
            cmd.acc = 1'b1;
            if (drain_ff == 2'd0) state_in = S_EMIT;
            else drain_in = drain_ff - 2'd1;
         end
         S_EMIT: begin
            // hold finished sum in the pending slot; last decided at the end
            if (sts.sum_nz) begin
               if (ov_ff && !ovalid_in) begin
                  ovalid_in = 1'b1; ov_in = 1'b0;
               end else if (!ov_ff && !ovalid_in) begin
                  out_in.result_col = cur_col; out_in.result_value = cur_sum;
                  out_in.status = ST_OK; out_in.empty_res = 1'b0; out_in.last = 1'b0;
                  ov_in = 1'b1; any_in = 1'b1;
                  cmd.col_next = 1'b1; cmd.scan_start = 1'b1; state_in = S_SCAN;
               end
            end else begin
               cmd.col_next = 1'b1; cmd.scan_start = 1'b1; state_in = S_SCAN;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; drain_ff <= '0; any_ff <= 1'b0; ov_ff <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; drain_ff <= drain_in; any_ff <= any_in; ov_ff <= ov_in;
         ovalid_ff <= ovalid_in;
      end
      out_ff <= out_in;
   end

endmodule

/* rtl/sparse_vector_matrix_multiply.sv */
// sparse_vector_matrix_multiply: top level joining controller and datapath.
// Depends on svmm_pkg, svmm_if, svmm_ctrl, svmm_datapath.
//
//   channel  dir  handshake          payload
//   req      in   valid/ready        operation, row_index, col_index, value
//   rsp      out  valid/ready        result_col, result_value, status, empty_res, last
//   csr      in   write enable only  index, 7-bit data
//
// Set-matrix runs a linear search over the entry memory read port.
// Multiply: one entry read per cycle per column, over every stored entry.
// A result is held one column back so the final one can carry last.
// Synchronous active-high reset; vector reads as zero, entry memory is not cleared.
// A stalled rsp holds the sequence at the next emitted result.
module sparse_vector_matrix_multiply
   import svmm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   svmm_if.sink             req,
   svmm_if.source           rsp,
   input  logic             csr_write,
   input  logic [1:0]       csr_index,
   input  logic [CFG_W-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;
   logic [IDX_W-1:0]      cur_col;
   logic [DATA_WIDTH-1:0] cur_sum;

   svmm_datapath u_dp (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .item(req.data), .cmd, .sts, .cur_col, .cur_sum
   );

   svmm_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready),
      .cmd, .sts, .cur_col, .cur_sum,
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
   );

endmodule

/* test/svmm_checker.sv */
`timescale 1ns / 1ps
// svmm_checker: watches the req, rsp and csr ports, predicts each response
// (acknowledge or product result) and compares it. Depends on svmm_pkg.
module svmm_checker
   import svmm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rsp_type          rsp_data,
   input  logic             csr_write,
   input  logic [1:0]       csr_index,
   input  logic [CFG_W-1:0] csr_data,
   output int               fail_count,
   output int               pending_count,
   output int               rsp_total
);
   logic [CFG_W-1:0]      vlen_reg, rows_reg, cols_reg;
   logic [DATA_WIDTH-1:0] vec_mem [MAX_DIM];
   logic [IDX_W-1:0]      ent_row [MAX_NONZERO];
   logic [IDX_W-1:0]      ent_col [MAX_NONZERO];
   logic [DATA_WIDTH-1:0] ent_val [MAX_NONZERO];
   int                    ent_count;
   rsp_type               product_queue [$];

   function automatic int clip(logic [CFG_W-1:0] r);
      return (r > MAX_DIM) ? MAX_DIM : int'(r);
   endfunction

   task automatic push_ack(logic [1:0] st);
      rsp_type a;
      a = '0;
      a.status = st;
      a.empty_res = 1'b1;
      a.last = 1'b1;
      product_queue.push_back(a);
   endtask

   task automatic predict_item(req_type it);
      int vl, nr, nc, n, k;
      logic [DATA_WIDTH-1:0] sum;
      rsp_type r;
      bit found;
      vl = clip(vlen_reg);
      nr = clip(rows_reg);
      nc = clip(cols_reg);
      case (it.operation)
         OP_CLEAR: begin
            foreach (vec_mem[i]) vec_mem[i] = '0;
            ent_count = 0;
            push_ack(ST_OK);
         end
         OP_SETV: begin
            if (it.row_index >= vl) push_ack(ST_RANGE);
            else begin
               vec_mem[it.row_index] = it.value;
               push_ack(ST_OK);
            end
         end
         OP_SETM: begin
            found = 0;
            if (it.row_index >= nr || it.col_index >= nc) push_ack(ST_RANGE);
            else begin
               for (k = 0; k < ent_count; k++)
                  if (!found && ent_row[k] == it.row_index && ent_col[k] == it.col_index) begin
                     ent_val[k] = it.value;
                     found = 1;
                  end
               if (found) push_ack(ST_OK);
               else if (ent_count >= MAX_NONZERO) push_ack(ST_FULL);
               else begin
                  ent_row[ent_count] = it.row_index;
                  ent_col[ent_count] = it.col_index;
                  ent_val[ent_count] = it.value;
                  ent_count++;
                  push_ack(ST_OK);
               end
            end
         end
         default: begin
            if (vlen_reg != rows_reg) push_ack(ST_DIM);
            else begin
               n = 0;
               for (int c = 0; c < nc; c++) begin
                  sum = '0;
                  for (k = 0; k < ent_count; k++)
                     if (ent_col[k] == c && ent_row[k] < vl && ent_row[k] < nr)
                        sum = sum + vec_mem[ent_row[k]] * ent_val[k];
                  if (sum != 0) begin
                     r = '0;
                     r.result_col = IDX_W'(c);
                     r.result_value = sum;
                     product_queue.push_back(r);
                     n++;
                  end
               end
               if (n == 0) push_ack(ST_OK);
               else product_queue[$].last = 1'b1;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         vlen_reg <= 1; rows_reg <= 1; cols_reg <= 1;
         foreach (vec_mem[i]) vec_mem[i] = '0;
         ent_count = 0;
         product_queue.delete();
         fail_count <= 0;
         rsp_total <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_total <= rsp_total + 1;
            if (product_queue.size() == 0) begin
               $display("%0t: unexpected result, got %p", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               if (rsp_data !== product_queue[0]) begin
                  $display("%0t: mismatch, expected %p, got %p", $time,
                           product_queue[0], rsp_data);
                  fail_count <= fail_count + 1;
               end
               void'(product_queue.pop_front());
            end
         end
         if (req_valid && req_ready) predict_item(req_data);
         if (csr_write) begin
            case (csr_index)
               CSR_VLEN: vlen_reg <= csr_data;
               CSR_ROWS: rows_reg <= csr_data;
               CSR_COLS: cols_reg <= csr_data;
               default: ;
            endcase
         end
      end
   end

   assign pending_count = product_queue.size();
endmodule

/* test/sparse_vector_matrix_multiply_tb.sv */
`timescale 1ns / 1ps
// sparse_vector_matrix_multiply_tb: drives items and csr writes into the block
// and gives the verdict. Uses svmm_pkg, svmm_if, svmm_checker, top level.
module sparse_vector_matrix_multiply_tb;
   import svmm_pkg::*;

   logic             clock;
   logic             reset;
   logic             csr_write;
   logic [1:0]       csr_index;
   logic [CFG_W-1:0] csr_data;
   int               fail_count, pending_count, rsp_total;
   int               idle_cycles;
   int               item_count;
   int               mul_count;

   svmm_if #(.payload_type(req_type)) req_ch (.clock(clock));
   svmm_if #(.payload_type(rsp_type)) rsp_ch (.clock(clock));

   sparse_vector_matrix_multiply DUT (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   svmm_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_data(req_ch.data),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_data(rsp_ch.data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count), .rsp_total(rsp_total)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Watchdog: allow well beyond a multiply over a full store plus a full
   // receiver stall.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 100000) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Receiver: random stall per item, with stall-free stretches.
   initial begin
      int wait_n;
      rsp_ch.ready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
         rsp_ch.ready = 0;
         repeat (wait_n) @(negedge clock);
         rsp_ch.ready = 1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic csr_put(logic [1:0] idx, logic [CFG_W-1:0] val);
      csr_write = 1; csr_index = idx; csr_data = val;
      @(negedge clock);
      csr_write = 0;
   endtask

   // Wait for the block to drain before touching registers.
   task automatic drain();
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic send_item(logic [1:0] op, logic [5:0] row, logic [5:0] col,
                            logic [31:0] val, bit gaps);
      int wait_n;
      wait_n = gaps ? $urandom_range(0, 19) : 0;
      if (wait_n > 0) begin
         req_ch.valid = 0;
         repeat (wait_n) @(negedge clock);
      end
      req_ch.valid = 1;
      req_ch.data = '{operation: op, row_index: row, col_index: col, value: val};
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      item_count++;
      if (op == OP_MUL) mul_count++;
      @(negedge clock);
      req_ch.valid = 0;
   endtask

   task automatic set_dims(logic [CFG_W-1:0] v, logic [CFG_W-1:0] r, logic [CFG_W-1:0] c);
      drain();
      csr_put(CSR_VLEN, v);
      csr_put(CSR_ROWS, r);
      csr_put(CSR_COLS, c);
   endtask

   initial begin
      int dim, pick;
      logic [1:0] op;
      logic [31:0] val;
      reset = 1;
      csr_write = 0; csr_index = CSR_VLEN; csr_data = '0;
      req_ch.valid = 0; req_ch.data = '0;
      item_count = 0; mul_count = 0;
      repeat (6) @(negedge clock);
      reset = 0;

      // Directed: reset dims, empty product, range errors, mismatch.
      send_item(OP_MUL, 0, 0, 0, 0);
      send_item(OP_SETV, 1, 0, 5, 0);
      send_item(OP_SETM, 0, 1, 5, 0);
      send_item(OP_SETV, 0, 0, 32'h8000_0000, 0);
      send_item(OP_SETM, 0, 0, 32'hFFFF_FFFF, 0);
      send_item(OP_MUL, 0, 0, 0, 0);
      send_item(OP_SETM, 0, 0, 0, 0);     // zero entry kept, overwrite
      send_item(OP_MUL, 0, 0, 0, 0);
      set_dims(7'd64, 7'd64, 7'd64);
      send_item(OP_SETV, 63, 0, 32'h7FFF_FFFF, 0);
      send_item(OP_SETM, 63, 63, 32'h7FFF_FFFF, 0);
      send_item(OP_SETM, 63, 0, 32'h8000_0000, 0);
      send_item(OP_MUL, 0, 0, 0, 0);
      set_dims(7'd127, 7'd127, 7'd127);   // oversized acts as 64
      send_item(OP_MUL, 0, 0, 0, 0);
      send_item(OP_SETV, 63, 63, 1, 0);
      set_dims(7'd5, 7'd4, 7'd3);
      send_item(OP_MUL, 0, 0, 0, 0);      // mismatch
      set_dims(7'd4, 7'd4, 7'd3);         // stale entries ignored
      send_item(OP_MUL, 0, 0, 0, 0);
      set_dims(7'd0, 7'd0, 7'd0);
      send_item(OP_SETV, 0, 0, 1, 0);
      send_item(OP_SETM, 0, 0, 1, 0);
      send_item(OP_MUL, 0, 0, 0, 0);
      send_item(OP_CLEAR, 0, 0, 0, 0);

      // Store full: fill 256 entries in an 16x16 matrix, then one more.
      set_dims(7'd17, 7'd17, 7'd16);
      for (int i = 0; i < 256; i++)
         send_item(OP_SETM, 6'(i / 16), 6'(i % 16), $urandom, 0);
      send_item(OP_SETM, 16, 0, 1, 0);    // full
      send_item(OP_SETM, 3, 4, 9, 0);     // overwrite still ok
      send_item(OP_SETV, 3, 0, 2, 0);
      send_item(OP_MUL, 0, 0, 0, 0);
      send_item(OP_CLEAR, 0, 0, 0, 0);

      // Random phases: small dims mostly, random items mostly in range, then multiply.
      for (int ph = 0; ph < 12; ph++) begin
         dim = (ph == 5) ? 64 : $urandom_range(1, 8);
         if ($urandom_range(0, 4) == 0)
            set_dims(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                     7'($urandom_range(0, 127)));
         else
            set_dims(7'(dim), 7'(dim), 7'($urandom_range(1, dim)));
         for (int j = 0; j < 17; j++) begin
            pick = $urandom_range(0, 19);
            op = (pick < 7) ? OP_SETV : (pick < 16) ? OP_SETM :
                 (pick < 19) ? OP_MUL : OP_CLEAR;
            val = ($urandom_range(0, 5) == 0) ? 32'(0 - $urandom_range(0, 1)) : $urandom;
            if ($urandom_range(0, 9) == 0)
               send_item(op, 6'($urandom), 6'($urandom), val, 1);
            else
               send_item(op, 6'($urandom_range(0, dim - 1)),
                         6'($urandom_range(0, dim - 1)), val, 1);
         end
         send_item(OP_MUL, 6'($urandom), 6'($urandom), $urandom, 1);
         if (ph == 3) begin
            // Hold off until the block has delivered everything.
            while (pending_count != 0) @(negedge clock);
         end
      end

      drain();
      repeat (100) @(negedge clock);
      $display("Ran %0d items (%0d multiplies), %0d results checked.",
               item_count, mul_count, rsp_total);
      if (fail_count == 0 && pending_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

/* sim.f */
rtl/svmm_pkg.sv
rtl/svmm_if.sv
rtl/svmm_datapath.sv
rtl/svmm_ctrl.sv
rtl/sparse_vector_matrix_multiply.sv
test/svmm_checker.sv
test/sparse_vector_matrix_multiply_tb.sv
